[sv/mdh_pkg.sv]
package mdh_pkg;

    localparam int MDH_ANGLE_BITS  = 16;
    localparam int MDH_LENGTH_BITS = 32;

    // CORDIC works on a 32-bit turn with 30 fraction bits in x/y
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 33;
    // pre-rotation stage + one stage per step + round/saturate stage
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 33'sd652032874;

    typedef struct packed {
        logic signed [15:0] cos_v;
        logic signed [15:0] sin_v;
    } t_trig;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [CORDIC_W-1:0] arc_step(input int idx);
        logic signed [CORDIC_W-1:0] v;
        case (idx)
            0:       v = 33'sd536870912;
            1:       v = 33'sd316933406;
            2:       v = 33'sd167458907;
            3:       v = 33'sd85004756;
            4:       v = 33'sd42667331;
            5:       v = 33'sd21354465;
            6:       v = 33'sd10679838;
            7:       v = 33'sd5340245;
            8:       v = 33'sd2670163;
            9:       v = 33'sd1335087;
            10:      v = 33'sd667544;
            11:      v = 33'sd333772;
            12:      v = 33'sd166886;
            13:      v = 33'sd83443;
            14:      v = 33'sd41722;
            15:      v = 33'sd20861;
            16:      v = 33'sd10430;
            17:      v = 33'sd5215;
            18:      v = 33'sd2608;
            19:      v = 33'sd1304;
            20:      v = 33'sd652;
            21:      v = 33'sd326;
            22:      v = 33'sd163;
            23:      v = 33'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // clamp an already rounded value to Q1.15
    function automatic logic signed [15:0] sat_q15(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

[sv/mdh_item_if.sv]
interface mdh_item_if #(
    parameter int ANGLE_BITS  = 16,
    parameter int LENGTH_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic        [3:0]             joint_index;
    logic signed [ANGLE_BITS-1:0]  joint_angle;
    logic signed [ANGLE_BITS-1:0]  twist_angle;
    logic signed [LENGTH_BITS-1:0] link_length;
    logic signed [LENGTH_BITS-1:0] link_offset;

    modport source (
        output valid, joint_index, joint_angle, twist_angle, link_length, link_offset,
        input  ready
    );
    modport sink (
        input  valid, joint_index, joint_angle, twist_angle, link_length, link_offset,
        output ready
    );
endinterface

[sv/mdh_result_if.sv]
interface mdh_result_if #(
    parameter int LENGTH_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic        [3:0]             joint_tag;
    logic signed [15:0]            cos_joint;
    logic signed [15:0]            sin_joint;
    logic signed [LENGTH_BITS-1:0] x_shift;
    logic signed [15:0]            sin_joint_cos_twist;
    logic signed [15:0]            cos_joint_cos_twist;
    logic signed [15:0]            sin_twist;
    logic signed [LENGTH_BITS-1:0] offset_sin_twist;
    logic signed [15:0]            sin_joint_sin_twist;
    logic signed [15:0]            cos_joint_sin_twist;
    logic signed [15:0]            cos_twist;
    logic signed [LENGTH_BITS-1:0] offset_cos_twist;

    modport source (
        output valid, joint_tag, cos_joint, sin_joint, x_shift, sin_joint_cos_twist,
               cos_joint_cos_twist, sin_twist, offset_sin_twist, sin_joint_sin_twist,
               cos_joint_sin_twist, cos_twist, offset_cos_twist,
        input  ready
    );
    modport sink (
        input  valid, joint_tag, cos_joint, sin_joint, x_shift, sin_joint_cos_twist,
               cos_joint_cos_twist, sin_twist, offset_sin_twist, sin_joint_sin_twist,
               cos_joint_sin_twist, cos_twist, offset_cos_twist,
        output ready
    );
endinterface

[sv/mdh_cordic.sv]
module mdh_cordic
    import mdh_pkg::*;
#(
    parameter int ANGLE_BITS = MDH_ANGLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [ANGLE_BITS-1:0] i_angle,
    output t_trig                        o_trig
);

    logic [31:0]                n_turn;
    logic                       n_flip;
    logic signed [CORDIC_W-1:0] n_z0;

    logic signed [CORDIC_W-1:0] r_x    [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] r_y    [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] r_z    [0:CORDIC_STEPS];
    logic                       r_flip [0:CORDIC_STEPS];
    t_trig                      r_trig;

    // scale to a 32-bit turn; quadrants 1 and 2 rotate by half a turn
    always_comb begin
        n_turn = {i_angle, {(32 - ANGLE_BITS){1'b0}}};
        n_flip = n_turn[31] ^ n_turn[30];
        n_z0   = {{(CORDIC_W - 31){n_turn[31] ^ n_flip}}, n_turn[30:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= CORDIC_START;
            r_y[0]    <= '0;
            r_z[0]    <= n_z0;
            r_flip[0] <= n_flip;
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        logic signed [CORDIC_W-1:0] n_dx;
        logic signed [CORDIC_W-1:0] n_dy;

        always_comb begin
            n_dx = r_y[g] >>> g;
            n_dy = r_x[g] >>> g;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][CORDIC_W-1]) begin
                    r_x[g+1] <= r_x[g] - n_dx;
                    r_y[g+1] <= r_y[g] + n_dy;
                    r_z[g+1] <= r_z[g] - arc_step(g);
                end else begin
                    r_x[g+1] <= r_x[g] + n_dx;
                    r_y[g+1] <= r_y[g] - n_dy;
                    r_z[g+1] <= r_z[g] + arc_step(g);
                end
                r_flip[g+1] <= r_flip[g];
            end
        end
    end

    logic signed [CORDIC_W:0] n_xs;
    logic signed [CORDIC_W:0] n_ys;
    logic signed [CORDIC_W:0] n_xr;
    logic signed [CORDIC_W:0] n_yr;

    always_comb begin
        n_xs = {r_x[CORDIC_STEPS][CORDIC_W-1], r_x[CORDIC_STEPS]};
        n_ys = {r_y[CORDIC_STEPS][CORDIC_W-1], r_y[CORDIC_STEPS]};
        if (r_flip[CORDIC_STEPS]) begin
            n_xs = -n_xs;
            n_ys = -n_ys;
        end
        n_xr = (n_xs + (CORDIC_W + 1)'(16384)) >>> 15;
        n_yr = (n_ys + (CORDIC_W + 1)'(16384)) >>> 15;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trig.cos_v <= sat_q15(n_xr[19:0]);
            r_trig.sin_v <= sat_q15(n_yr[19:0]);
        end
    end

    assign o_trig = r_trig;

endmodule

[sv/modified_dh_link_transform_unit.sv]
// Modified DH link transform: one joint per item, one result per item.
// Input channel i_item (sink): joint index, joint angle and twist as signed
// binary angles (half a turn = 2^(ANGLE_BITS-1)), link length and offset as
// signed Q16.16. Output channel o_result (source): the variable entries of
// the 4x4 link transform - cos/sin of joint and twist in Q1.15, their four
// cross products, the length passed through and offset times sin/cos of
// the twist, plus the echoed joint tag.
// Throughput: one item per cycle while the skid register is empty. The
// accepting edge loads the first of the 26 CORDIC stages (pre-rotation, 24
// steps, round), followed by a multiply stage, a round and saturate stage and
// the output register, which drives o_result.valid.
// Handshake: an item moves when valid and ready are both high.
// Stall: an output register plus one skid register sit behind the pipeline;
// i_item.ready drops only while the skid register holds an item, which also
// freezes every stage, so nothing is lost or repeated.
// Reset (i_rst_n low, synchronous): all valid bits clear, the pipeline is
// empty and i_item.ready is high in the following cycle.
module modified_dh_link_transform_unit
    import mdh_pkg::*;
#(
    parameter int ANGLE_BITS  = MDH_ANGLE_BITS,
    parameter int LENGTH_BITS = MDH_LENGTH_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mdh_item_if.sink            i_item,
    mdh_result_if.source        o_result
);

    localparam int PW = LENGTH_BITS + 16;   // offset x trig product width
    localparam logic signed [PW-1:0] L_RND = PW'(16384);
    localparam logic signed [PW-1:0] L_MAX = PW'((64'sd1 <<< (LENGTH_BITS - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] L_MIN = -L_MAX - PW'(1);

    typedef struct packed {
        logic [3:0]                    joint_tag;
        logic signed [15:0]            cos_joint;
        logic signed [15:0]            sin_joint;
        logic signed [LENGTH_BITS-1:0] x_shift;
        logic signed [15:0]            sin_joint_cos_twist;
        logic signed [15:0]            cos_joint_cos_twist;
        logic signed [15:0]            sin_twist;
        logic signed [LENGTH_BITS-1:0] offset_sin_twist;
        logic signed [15:0]            sin_joint_sin_twist;
        logic signed [15:0]            cos_joint_sin_twist;
        logic signed [15:0]            cos_twist;
        logic signed [LENGTH_BITS-1:0] offset_cos_twist;
    } t_res;

    // whole pipeline advances unless the skid register is occupied
    logic  en;
    logic  r_skid_valid;
    logic  r_out_valid;
    t_res  r_skid;
    t_res  r_out;

    assign en           = !r_skid_valid;
    assign i_item.ready = en;

    // ---------------- trig units ----------------
    t_trig joint_trig;
    t_trig twist_trig;

    mdh_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_joint_cordic (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_item.joint_angle),
        .o_trig  (joint_trig)
    );

    mdh_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_twist_cordic (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_item.twist_angle),
        .o_trig  (twist_trig)
    );

    // ---------------- side-band delay line, aligned with the trig units ----
    logic                          r_vld [0:CORDIC_LAT-1];
    logic [3:0]                    r_tag [0:CORDIC_LAT-1];
    logic signed [LENGTH_BITS-1:0] r_len [0:CORDIC_LAT-1];
    logic signed [LENGTH_BITS-1:0] r_off [0:CORDIC_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORDIC_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_item.valid;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[0] <= i_item.joint_index;
            r_len[0] <= i_item.link_length;
            r_off[0] <= i_item.link_offset;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_tag[k] <= r_tag[k-1];
                r_len[k] <= r_len[k-1];
                r_off[k] <= r_off[k-1];
            end
        end
    end

    // ---------------- product stage ----------------
    logic                          r_p_vld;
    logic [3:0]                    r_p_tag;
    logic signed [LENGTH_BITS-1:0] r_p_len;
    t_trig                         r_p_jt;
    t_trig                         r_p_tt;
    logic signed [31:0]            r_p_sjct;
    logic signed [31:0]            r_p_cjct;
    logic signed [31:0]            r_p_sjst;
    logic signed [31:0]            r_p_cjst;
    logic signed [PW-1:0]          r_p_dst;
    logic signed [PW-1:0]          r_p_dct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (en) begin
            r_p_vld <= r_vld[CORDIC_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_tag  <= r_tag[CORDIC_LAT-1];
            r_p_len  <= r_len[CORDIC_LAT-1];
            r_p_jt   <= joint_trig;
            r_p_tt   <= twist_trig;
            r_p_sjct <= $signed(joint_trig.sin_v) * $signed(twist_trig.cos_v);
            r_p_cjct <= $signed(joint_trig.cos_v) * $signed(twist_trig.cos_v);
            r_p_sjst <= $signed(joint_trig.sin_v) * $signed(twist_trig.sin_v);
            r_p_cjst <= $signed(joint_trig.cos_v) * $signed(twist_trig.sin_v);
            r_p_dst  <= $signed(r_off[CORDIC_LAT-1]) * $signed(twist_trig.sin_v);
            r_p_dct  <= $signed(r_off[CORDIC_LAT-1]) * $signed(twist_trig.cos_v);
        end
    end

    // ---------------- round and saturate stage ----------------
    logic signed [31:0]            n_sjct;
    logic signed [31:0]            n_cjct;
    logic signed [31:0]            n_sjst;
    logic signed [31:0]            n_cjst;
    logic signed [PW-1:0]          n_dst;
    logic signed [PW-1:0]          n_dct;
    logic signed [LENGTH_BITS-1:0] n_dst_sat;
    logic signed [LENGTH_BITS-1:0] n_dct_sat;
    t_res                          n_q;

    always_comb begin
        n_sjct = (r_p_sjct + 32'sd16384) >>> 15;
        n_cjct = (r_p_cjct + 32'sd16384) >>> 15;
        n_sjst = (r_p_sjst + 32'sd16384) >>> 15;
        n_cjst = (r_p_cjst + 32'sd16384) >>> 15;
        n_dst  = (r_p_dst + L_RND) >>> 15;
        n_dct  = (r_p_dct + L_RND) >>> 15;

        if (n_dst > L_MAX) begin
            n_dst_sat = L_MAX[LENGTH_BITS-1:0];
        end else if (n_dst < L_MIN) begin
            n_dst_sat = L_MIN[LENGTH_BITS-1:0];
        end else begin
            n_dst_sat = n_dst[LENGTH_BITS-1:0];
        end
        if (n_dct > L_MAX) begin
            n_dct_sat = L_MAX[LENGTH_BITS-1:0];
        end else if (n_dct < L_MIN) begin
            n_dct_sat = L_MIN[LENGTH_BITS-1:0];
        end else begin
            n_dct_sat = n_dct[LENGTH_BITS-1:0];
        end

        n_q.joint_tag           = r_p_tag;
        n_q.cos_joint           = r_p_jt.cos_v;
        n_q.sin_joint           = r_p_jt.sin_v;
        n_q.x_shift             = r_p_len;
        n_q.sin_joint_cos_twist = sat_q15(n_sjct[19:0]);
        n_q.cos_joint_cos_twist = sat_q15(n_cjct[19:0]);
        n_q.sin_twist           = r_p_tt.sin_v;
        n_q.offset_sin_twist    = n_dst_sat;
        n_q.sin_joint_sin_twist = sat_q15(n_sjst[19:0]);
        n_q.cos_joint_sin_twist = sat_q15(n_cjst[19:0]);
        n_q.cos_twist           = r_p_tt.cos_v;
        n_q.offset_cos_twist    = n_dct_sat;
    end

    logic r_q_vld;
    t_res r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else if (en) begin
            r_q_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q <= n_q;
        end
    end

    // ---------------- output register + skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_skid_valid) begin
            if (!r_out_valid || o_result.ready) begin
                r_out_valid <= r_q_vld;
                r_out       <= r_q;
            end else if (r_q_vld) begin
                // output stalled: park the item leaving the pipeline
                r_skid_valid <= 1'b1;
                r_skid       <= r_q;
            end
        end else if (o_result.ready) begin
            r_out        <= r_skid;
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end
    end

    assign o_result.valid               = r_out_valid;
    assign o_result.joint_tag           = r_out.joint_tag;
    assign o_result.cos_joint           = r_out.cos_joint;
    assign o_result.sin_joint           = r_out.sin_joint;
    assign o_result.x_shift             = r_out.x_shift;
    assign o_result.sin_joint_cos_twist = r_out.sin_joint_cos_twist;
    assign o_result.cos_joint_cos_twist = r_out.cos_joint_cos_twist;
    assign o_result.sin_twist           = r_out.sin_twist;
    assign o_result.offset_sin_twist    = r_out.offset_sin_twist;
    assign o_result.sin_joint_sin_twist = r_out.sin_joint_sin_twist;
    assign o_result.cos_joint_sin_twist = r_out.cos_joint_sin_twist;
    assign o_result.cos_twist           = r_out.cos_twist;
    assign o_result.offset_cos_twist    = r_out.offset_cos_twist;

`ifndef NO_ASSERTIONS
    // skid only fills behind a stalled output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an item while output register is empty");

    // an item leaving the pipeline into a stalled output must be parked
    a_park_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_q_vld && r_out_valid && !o_result.ready) |=> r_skid_valid)
        else $error("item dropped at stalled output");

    // every accepted item enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> r_vld[0])
        else $error("accepted item not captured");
`endif

endmodule

[bench/tb_modified_dh_link_transform_unit.sv]
module tb_modified_dh_link_transform_unit;
    import mdh_pkg::*;

    localparam int AW = MDH_ANGLE_BITS;
    localparam int LW = MDH_LENGTH_BITS;

    localparam int  TOTAL_RANDOM = 1700;
    localparam int  DRAIN_CYCLES = 64;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  REPORT_MAX   = 10;

    // CORDIC seed (30 fraction bits) and arctangent steps in 2^-32 turn units
    localparam longint ROT_X0 = 64'sd652032874;
    localparam longint ATAN_TURN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    typedef struct {
        logic        [3:0]    joint_index;
        logic signed [AW-1:0] joint_angle;
        logic signed [AW-1:0] twist_angle;
        logic signed [LW-1:0] link_length;
        logic signed [LW-1:0] link_offset;
    } joint_item_t;

    typedef struct {
        logic        [3:0]    joint_tag;
        logic signed [15:0]   cos_joint;
        logic signed [15:0]   sin_joint;
        logic signed [LW-1:0] x_shift;
        logic signed [15:0]   sin_joint_cos_twist;
        logic signed [15:0]   cos_joint_cos_twist;
        logic signed [15:0]   sin_twist;
        logic signed [LW-1:0] offset_sin_twist;
        logic signed [15:0]   sin_joint_sin_twist;
        logic signed [15:0]   cos_joint_sin_twist;
        logic signed [15:0]   cos_twist;
        logic signed [LW-1:0] offset_cos_twist;
    } link_entries_t;

    class dh_transform_checker;
        link_entries_t pending_transforms[$];
        int            joints_seen;
        int            transforms_checked;
        int            mismatches;

        function longint clamp(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                return hi;
            end else if (v < lo) begin
                return lo;
            end
            return v;
        endfunction

        // round half up, drop 15 fraction bits, then clamp to the given width
        function longint round_q15(longint v, int bits);
            return clamp((v + (longint'(1) <<< 14)) >>> 15, bits);
        endfunction

        function void rotate(input logic [AW-1:0] raw, output longint c, output longint s);
            logic [31:0] u;
            logic        flip;
            longint      x;
            longint      y;
            longint      z;
            longint      dx;
            longint      dy;
            u = 32'(raw) << (32 - AW);
            // quadrants 1 and 2 fold by half a turn, sign restored at the end
            flip = (u[31:30] == 2'b01) || (u[31:30] == 2'b10);
            if (flip) begin
                u[31] = ~u[31];
            end
            z = longint'($signed(u));
            x = ROT_X0;
            y = 0;
            for (int i = 0; i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= ATAN_TURN[i];
                end else begin
                    x += dx;
                    y -= dy;
                    z += ATAN_TURN[i];
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            c = round_q15(x, 16);
            s = round_q15(y, 16);
        endfunction

        function link_entries_t predict_transform(joint_item_t it);
            longint        cj;
            longint        sj;
            longint        ct;
            longint        st;
            longint        off;
            link_entries_t e;
            rotate(it.joint_angle, cj, sj);
            rotate(it.twist_angle, ct, st);
            off = longint'(it.link_offset);
            e.joint_tag           = it.joint_index;
            e.cos_joint           = cj[15:0];
            e.sin_joint           = sj[15:0];
            e.x_shift             = it.link_length;
            e.sin_joint_cos_twist = 16'(round_q15(sj * ct, 16));
            e.cos_joint_cos_twist = 16'(round_q15(cj * ct, 16));
            e.sin_twist           = st[15:0];
            e.offset_sin_twist    = LW'(round_q15(off * st, LW));
            e.sin_joint_sin_twist = 16'(round_q15(sj * st, 16));
            e.cos_joint_sin_twist = 16'(round_q15(cj * st, 16));
            e.cos_twist           = ct[15:0];
            e.offset_cos_twist    = LW'(round_q15(off * ct, LW));
            return e;
        endfunction

        function void note_joint(joint_item_t it);
            pending_transforms.push_back(predict_transform(it));
            joints_seen++;
        endfunction

        function int pending();
            return pending_transforms.size();
        endfunction

        function void compare_field(string name, logic [3:0] tag, longint want, longint got);
            if (want != got) begin
                if (mismatches < REPORT_MAX) begin
                    $display("mismatch joint %0d %s: expected %0d, got %0d",
                             tag, name, want, got);
                end
                mismatches++;
            end
        endfunction

        function void check_transform(link_entries_t got);
            link_entries_t want;
            if (pending_transforms.size() == 0) begin
                if (mismatches < REPORT_MAX) begin
                    $display("mismatch: transform for joint %0d with no item pending",
                             got.joint_tag);
                end
                mismatches++;
                return;
            end
            want = pending_transforms.pop_front();
            transforms_checked++;
            compare_field("joint_tag", want.joint_tag, want.joint_tag, got.joint_tag);
            compare_field("cos_joint", want.joint_tag, want.cos_joint, got.cos_joint);
            compare_field("sin_joint", want.joint_tag, want.sin_joint, got.sin_joint);
            compare_field("x_shift", want.joint_tag, want.x_shift, got.x_shift);
            compare_field("sin_joint_cos_twist", want.joint_tag,
                          want.sin_joint_cos_twist, got.sin_joint_cos_twist);
            compare_field("cos_joint_cos_twist", want.joint_tag,
                          want.cos_joint_cos_twist, got.cos_joint_cos_twist);
            compare_field("sin_twist", want.joint_tag, want.sin_twist, got.sin_twist);
            compare_field("offset_sin_twist", want.joint_tag,
                          want.offset_sin_twist, got.offset_sin_twist);
            compare_field("sin_joint_sin_twist", want.joint_tag,
                          want.sin_joint_sin_twist, got.sin_joint_sin_twist);
            compare_field("cos_joint_sin_twist", want.joint_tag,
                          want.cos_joint_sin_twist, got.cos_joint_sin_twist);
            compare_field("cos_twist", want.joint_tag, want.cos_twist, got.cos_twist);
            compare_field("offset_cos_twist", want.joint_tag,
                          want.offset_cos_twist, got.offset_cos_twist);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mdh_item_if   #(.ANGLE_BITS(AW), .LENGTH_BITS(LW)) item_ch ();
    mdh_result_if #(.LENGTH_BITS(LW))                  result_ch ();

    modified_dh_link_transform_unit #(
        .ANGLE_BITS (AW),
        .LENGTH_BITS(LW)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_result(result_ch)
    );

    dh_transform_checker transform_sb = new();

    int cycle_count;
    int sender_idle_cycles;
    int receiver_stall_cycles;
    int drain_pauses;
    int directed_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cycle budget: a hang ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d transforms still pending",
                     cycle_count, transform_sb.pending());
            $display("tb_modified_dh_link_transform_unit: FAIL");
            $finish;
        end
    end

    // both handshakes sampled at the rising edge; input noted before output checked
    always @(posedge i_clk) begin
        link_entries_t seen;
        joint_item_t   taken;
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                taken.joint_index = item_ch.joint_index;
                taken.joint_angle = item_ch.joint_angle;
                taken.twist_angle = item_ch.twist_angle;
                taken.link_length = item_ch.link_length;
                taken.link_offset = item_ch.link_offset;
                transform_sb.note_joint(taken);
            end
            if (result_ch.valid && result_ch.ready) begin
                seen.joint_tag           = result_ch.joint_tag;
                seen.cos_joint           = result_ch.cos_joint;
                seen.sin_joint           = result_ch.sin_joint;
                seen.x_shift             = result_ch.x_shift;
                seen.sin_joint_cos_twist = result_ch.sin_joint_cos_twist;
                seen.cos_joint_cos_twist = result_ch.cos_joint_cos_twist;
                seen.sin_twist           = result_ch.sin_twist;
                seen.offset_sin_twist    = result_ch.offset_sin_twist;
                seen.sin_joint_sin_twist = result_ch.sin_joint_sin_twist;
                seen.cos_joint_sin_twist = result_ch.cos_joint_sin_twist;
                seen.cos_twist           = result_ch.cos_twist;
                seen.offset_cos_twist    = result_ch.offset_cos_twist;
                transform_sb.check_transform(seen);
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [AW-1:0] pick_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return AW'($urandom);
        end else if (r < 8) begin
            // near a quadrant boundary
            return AW'({2'($urandom_range(0, 3)), {(AW-2){1'b0}}}
                       + AW'($urandom_range(0, 8)) - 4);
        end
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return {1'b0, {(AW-1){1'b1}}};
            2:       return {1'b1, {(AW-1){1'b0}}};
            3:       return {2'b01, {(AW-2){1'b0}}};
            4:       return {2'b11, {(AW-2){1'b0}}};
            default: return '1;
        endcase
    endfunction

    function automatic logic [LW-1:0] pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            return LW'({$urandom, $urandom});
        end else if (r < 9) begin
            case ($urandom_range(0, 3))
                0:       return {1'b0, {(LW-1){1'b1}}};
                1:       return {1'b1, {(LW-1){1'b0}}};
                2:       return '0;
                default: return '1;
            endcase
        end
        // values within +/-8.0 in Q16.16 (a 20-bit signed raw value)
        return LW'($signed(20'($urandom)));
    endfunction

    task automatic drive_item(input joint_item_t it, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            item_ch.valid <= 1'b0;
            sender_idle_cycles++;
        end
        @(negedge i_clk);
        item_ch.valid       <= 1'b1;
        item_ch.joint_index <= it.joint_index;
        item_ch.joint_angle <= it.joint_angle;
        item_ch.twist_angle <= it.twist_angle;
        item_ch.link_length <= it.link_length;
        item_ch.link_offset <= it.link_offset;
        @(posedge i_clk);
        while (!item_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    // drop valid and hold off until every pending transform has come back
    task automatic drain_outputs();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (transform_sb.pending() != 0) begin
            @(posedge i_clk);
        end
        drain_pauses++;
    endtask

    // receiver: bursts of ready with random stalls, sometimes long quiet stretches
    task automatic run_receiver();
        int on_len;
        int off_len;
        int r;
        forever begin
            r = $urandom_range(0, 9);
            on_len  = (r < 2) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            r = $urandom_range(0, 99);
            if (r < 60) begin
                off_len = $urandom_range(1, 2);
            end else if (r < 92) begin
                off_len = $urandom_range(3, 8);
            end else begin
                off_len = $urandom_range(20, 40);
            end
            repeat (on_len) begin
                @(negedge i_clk);
                result_ch.ready <= 1'b1;
            end
            repeat (off_len) begin
                @(negedge i_clk);
                result_ch.ready <= 1'b0;
                receiver_stall_cycles++;
            end
        end
    endtask

    // directed angle pairs: zero, quarter turns, half turn, edges of each quadrant
    localparam logic signed [AW-1:0] DIR_JOINT [12] = '{
        0, 16384, -32768, -16384, 32767, 1, 8192, 16383, -16383, 24576, 0, -32768
    };
    localparam logic signed [AW-1:0] DIR_TWIST [12] = '{
        0, 16384, -32768, -16384, -1, 32767, -8192, 16385, -16385, -24576, -32768, 16384
    };
    localparam logic signed [LW-1:0] DIR_LEN [4] = '{
        {1'b0, {(LW-1){1'b1}}}, {1'b1, {(LW-1){1'b0}}}, '0, '1
    };

    initial begin
        joint_item_t it;
        int          gap;
        i_rst_n             = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.joint_index = '0;
        item_ch.joint_angle = '0;
        item_ch.twist_angle = '0;
        item_ch.link_length = '0;
        item_ch.link_offset = '0;
        result_ch.ready     = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        fork
            run_receiver();
        join_none

        // Directed: angle pairs with length and offset at full-scale corners.
        // Offset at the most negative value meets a half-turn twist twice, which
        // must clamp offset times cos twist to the largest positive length.
        for (int k = 0; k < 12; k++) begin
            it.joint_index = (k % 2 == 0) ? 4'(k) : 4'(15 - k);
            it.joint_angle = DIR_JOINT[k];
            it.twist_angle = DIR_TWIST[k];
            it.link_length = DIR_LEN[k % 4];
            it.link_offset = DIR_LEN[(k + 3) % 4];
            drive_item(it, k % 3);
            directed_count++;
        end
        // Most positive, then most negative offset against every quarter-turn twist.
        for (int k = 0; k < 8; k++) begin
            it.joint_index = 4'hF;
            it.joint_angle = DIR_JOINT[(k + 4) % 12];
            it.twist_angle = AW'(k * 16384);
            it.link_length = DIR_LEN[(k + 2) % 4];
            it.link_offset = DIR_LEN[k / 4];
            drive_item(it, 0);
            directed_count++;
        end
        drain_outputs();

        for (int n = 0; n < TOTAL_RANDOM; n++) begin
            it.joint_index = 4'($urandom_range(0, 15));
            it.joint_angle = pick_angle();
            it.twist_angle = pick_angle();
            it.link_length = pick_length();
            it.link_offset = pick_length();
            // every fourth block of 100 items runs back to back
            gap = ((n / 100) % 4 == 1) ? 0 : pick_gap();
            drive_item(it, gap);
            if (n == TOTAL_RANDOM / 3 || n == (2 * TOTAL_RANDOM) / 3) begin
                drain_outputs();
            end
        end
        drain_outputs();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d joint items (%0d directed corners), %0d transforms compared",
                 transform_sb.joints_seen, directed_count, transform_sb.transforms_checked);
        $display("sender idled %0d cycles, receiver stalled %0d cycles, %0d drain pauses",
                 sender_idle_cycles, receiver_stall_cycles, drain_pauses);
        if (transform_sb.mismatches == 0 && transform_sb.pending() == 0) begin
            $display("tb_modified_dh_link_transform_unit: PASS");
        end else begin
            $display("%0d mismatches, %0d transforms never arrived",
                     transform_sb.mismatches, transform_sb.pending());
            $display("tb_modified_dh_link_transform_unit: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
sv/mdh_pkg.sv
sv/mdh_item_if.sv
sv/mdh_result_if.sv
sv/mdh_cordic.sv
sv/modified_dh_link_transform_unit.sv
bench/tb_modified_dh_link_transform_unit.sv
